// ===== src/speed_step_ramp_generator_macros.svh =====
// assertion macros for the speed step ramp generator checker
`ifndef SPEED_STEP_RAMP_GENERATOR_MACROS_SVH
`define SPEED_STEP_RAMP_GENERATOR_MACROS_SVH

// checked outside reset
`define SSRG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SSRG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ssrg_pkg.sv =====
package ssrg_pkg;

	localparam int STEP_W    = 8;
	localparam int IDX_W     = 7;
	localparam int CNT_W     = 8;
	localparam int SP_W      = 12;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_W     = 18;
	localparam int KF_W      = 6;

	localparam logic [CFG_IDX_W-1:0] REG_UP_RATE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_RATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MID_CODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE  = 3'd4;

	localparam logic [STEP_W-1:0] ESTOP_FWD = 8'd1;
	localparam logic [STEP_W-1:0] ESTOP_REV = 8'd129;

	localparam logic [IDX_W-1:0] MID_IDX  = 7'd64;
	localparam logic [IDX_W-1:0] SEG_BASE = 7'd63;
	localparam logic [KF_W-1:0]  SEG_LEN  = 6'd63;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             reload;
	} ramp_upd_t;

	function automatic logic [IDX_W-1:0] target_index_of(input logic [STEP_W-1:0] step);
		logic [IDX_W-1:0] s;
		s = step[IDX_W-1:0];
		if (s <= 7'd1) begin
			return '0;
		end
		return s - 7'd1;
	endfunction

	// round(num / 63): floor((num + 31) / 63) via reciprocal 1040/2^16 and one correction
	function automatic logic [SP_W-1:0] div63_round(input logic [NUM_W-1:0] num);
		logic [NUM_W-1:0] y;
		logic [28:0]      prod;
		logic [12:0]      q_est;
		logic [18:0]      q63;
		logic [18:0]      r;
		logic [12:0]      q;
		y     = num + NUM_W'(31);
		prod  = ({11'b0, y} << 10) + ({11'b0, y} << 4);
		q_est = prod[28:16];
		q63   = ({6'b0, q_est} << 6) - {6'b0, q_est};
		r     = {1'b0, y} - q63;
		q     = (r >= 19'd63) ? q_est + 13'd1 : q_est;
		return q[SP_W-1:0];
	endfunction

endpackage

// ===== src/ssrg_if.sv =====
interface ssrg_in_if;
	import ssrg_pkg::*;
	logic              valid;
	logic              ready;
	logic [STEP_W-1:0] target_step;
	logic [STEP_W-1:0] previous_target_step;

	modport source (output valid, output target_step, output previous_target_step, input ready);
	modport sink (input valid, input target_step, input previous_target_step, output ready);
endinterface

interface ssrg_out_if;
	import ssrg_pkg::*;
	logic             valid;
	logic             ready;
	logic [SP_W-1:0]  setpoint;
	logic [IDX_W-1:0] table_index;

	modport source (output valid, output setpoint, output table_index, input ready);
	modport sink (input valid, input setpoint, input table_index, output ready);
endinterface

// ===== src/ssrg_ramp.sv =====
module ssrg_ramp
	import ssrg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [STEP_W-1:0] target_step,
	input  logic [STEP_W-1:0] previous_target_step,
	input  logic [CFG_W-1:0]  up_rate,
	input  logic [CFG_W-1:0]  down_rate,
	output ramp_upd_t         upd
);

	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_d;
	logic [CNT_W-1:0] cnt_d;
	logic [IDX_W-1:0] end_idx;
	logic             dir_chg;
	logic             estop;
	logic             reload;

	assign end_idx = target_index_of(target_step);
	assign dir_chg = target_step[STEP_W-1] ^ previous_target_step[STEP_W-1];
	assign estop   = (target_step == ESTOP_FWD) || (target_step == ESTOP_REV);

	always_comb begin
		idx_d  = idx_q;
		cnt_d  = cnt_q;
		reload = 1'b0;
		if (estop) begin
			idx_d  = '0;
			cnt_d  = '0;
			reload = 1'b1;
		end else if (end_idx > idx_q && cnt_q == up_rate) begin
			idx_d  = (up_rate == '0) ? end_idx : idx_q + 7'd1;
			cnt_d  = '0;
			reload = 1'b1;
		end else if (end_idx < idx_q && cnt_q == down_rate) begin
			idx_d  = (down_rate == '0) ? end_idx : idx_q - 7'd1;
			cnt_d  = '0;
			reload = 1'b1;
		end else if (dir_chg) begin
			idx_d  = end_idx;
			cnt_d  = '0;
			reload = 1'b1;
		end else if (end_idx != idx_q) begin
			cnt_d = cnt_q + 8'd1;
		end else begin
			cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			idx_q <= idx_d;
			cnt_q <= cnt_d;
		end
	end

	assign upd.idx    = idx_d;
	assign upd.reload = reload;

endmodule

// ===== src/speed_step_ramp_generator.sv =====
// channel   | dir | words                                  | handshake
// cmd_ch    | in  | target_step, previous_target_step      | valid / ready
// speed_ch  | out | setpoint, table_index                  | valid / ready
// cfg       | in  | cfg_index, cfg_data                    | cfg_we, no wait
//
// one word per cycle sustained while speed_ch is ready
// index and tick counter update at accept; the table entry takes two more stages
// (weighted sum with two small multipliers, then the divide by 63)
// arst_n clears the ramp state, the held setpoint and all stage valids
// each stage moves when the one after it is empty or moving, so bubbles fill under stall
module speed_step_ramp_generator
	import ssrg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	ssrg_in_if.sink              cmd_ch,
	ssrg_out_if.source           speed_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] up_rate_q;
	logic [CFG_W-1:0] down_rate_q;
	logic [CFG_W-1:0] min_speed_q;
	logic [CFG_W-1:0] mid_code_q;
	logic [CFG_W-1:0] max_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_rate_q   <= 8'd0;
			down_rate_q <= 8'd0;
			min_speed_q <= 8'd1;
			mid_code_q  <= 8'd128;
			max_code_q  <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UP_RATE:   up_rate_q   <= cfg_data;
				REG_DOWN_RATE: down_rate_q <= cfg_data;
				REG_MIN_SPEED: min_speed_q <= cfg_data;
				REG_MID_CODE:  mid_code_q  <= cfg_data;
				REG_MAX_CODE:  max_code_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic v_s1;
	logic v_s2;
	logic out_valid_q;
	logic en1;
	logic en2;
	logic en3;
	logic accept;

	assign en3          = !out_valid_q || speed_ch.ready;
	assign en2          = !v_s2 || en3;
	assign en1          = !v_s1 || en2;
	assign cmd_ch.ready = en1;
	assign accept       = cmd_ch.valid && en1;

	ramp_upd_t upd;

	ssrg_ramp u_ramp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.accept               (accept),
		.target_step          (cmd_ch.target_step),
		.previous_target_step (cmd_ch.previous_target_step),
		.up_rate              (up_rate_q),
		.down_rate            (down_rate_q),
		.upd                  (upd)
	);

	// stage 1: new index
	ramp_upd_t upd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			upd_s1 <= upd;
		end
	end

	// stage 2: weighted sum a*(63-k) + b*k
	logic [SP_W-1:0]  seg_a;
	logic [SP_W-1:0]  seg_b;
	logic [KF_W-1:0]  seg_k;
	logic [NUM_W-1:0] num;
	logic [NUM_W-1:0] num_s2;
	ramp_upd_t        upd_s2;

	always_comb begin
		seg_a = '0;
		seg_b = '0;
		seg_k = '0;
		if (upd_s1.idx == '0) begin
			seg_k = '0;
		end else if (upd_s1.idx < MID_IDX) begin
			seg_a = {4'b0, min_speed_q};
			seg_b = {mid_code_q, 4'b0};
			seg_k = KF_W'(upd_s1.idx - 7'd1);
		end else begin
			seg_a = {mid_code_q, 4'b0};
			seg_b = {max_code_q, 4'b0};
			seg_k = KF_W'(upd_s1.idx - SEG_BASE);
		end
	end

	assign num = ({6'b0, seg_a} * {12'b0, SEG_LEN - seg_k})
		+ ({6'b0, seg_b} * {12'b0, seg_k});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			num_s2 <= num;
			upd_s2 <= upd_s1;
		end
	end

	// stage 3: rounded divide, held setpoint lives in the output register
	logic [SP_W-1:0]  setpoint_q;
	logic [IDX_W-1:0] index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			setpoint_q  <= '0;
		end else if (en3) begin
			out_valid_q <= v_s2;
			if (v_s2 && upd_s2.reload) begin
				setpoint_q <= div63_round(num_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			index_q <= upd_s2.idx;
		end
	end

	assign speed_ch.valid       = out_valid_q;
	assign speed_ch.setpoint    = setpoint_q;
	assign speed_ch.table_index = index_q;

endmodule

// ===== src/ssrg_checker.sv =====
`include "speed_step_ramp_generator_macros.svh"

module ssrg_checker
	import ssrg_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [SP_W-1:0]  setpoint,
	input logic [IDX_W-1:0] table_index
);

	`SSRG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped under stall")
	`SSRG_ASSERT(a_index_range, out_valid |-> table_index != 7'd127, "table index beyond last entry")
	`SSRG_ASSERT(a_zero_entry, out_valid && table_index == '0 |-> setpoint == '0, "index 0 with nonzero setpoint")
	`SSRG_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind speed_step_ramp_generator ssrg_checker u_ssrg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (speed_ch.valid),
	.out_ready   (speed_ch.ready),
	.setpoint    (speed_ch.setpoint),
	.table_index (speed_ch.table_index)
);
